### rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

### rtl/core/dbse_pkg.sv
`timescale 1ns / 1ps
// Package: widths, command codes, interface structs and the power-of-ten table.
package dbse_pkg;

	localparam int ENTRIES     = 24;
	localparam int SLOTS       = 2 * ENTRIES;
	localparam int ADDR_W      = $clog2(SLOTS);
	localparam int PTR_W       = $clog2(SLOTS + 1);
	localparam int IDX_W       = 6;
	localparam int VAL_W       = 32;
	localparam int ENT_W       = 16;
	localparam int EXP_W       = 3;
	localparam int CMD_W       = 2;
	localparam int POW_W       = 17;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;
	localparam int OUT_PAD_W   = OUT_TDATA_W - VAL_W - EXP_W;
	localparam int ENTRY_MAX   = 65535;
	localparam int LOWER_LIMIT = ENTRY_MAX / 10;
	localparam int EXP_MAX     = 5;

	localparam logic [EXP_W-1:0] EXP_RESET = EXP_W'(1);
	localparam logic [PTR_W-1:0] PTR_END   = PTR_W'(SLOTS);

	typedef enum logic [CMD_W-1:0] {
		CMD_WR_IMPORT = 2'd0,
		CMD_WR_EXPORT = 2'd1,
		CMD_RD_IMPORT = 2'd2,
		CMD_RD_EXPORT = 2'd3
	} cmd_t;

	// Access to the entry store: one write and one read address per cycle.
	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [ENT_W-1:0]  wr_data;
		logic [ADDR_W-1:0] rd_addr;
	} mem_req_t;

	// One finished result.
	typedef struct packed {
		logic [VAL_W-1:0] energy;
		logic [EXP_W-1:0] exponent;
		logic             rejected;
	} result_t;

	function automatic logic [POW_W-1:0] pow10(input logic [EXP_W-1:0] e);
		logic [POW_W-1:0] p;
		unique case (e)
			3'd0:    p = POW_W'(1);
			3'd1:    p = POW_W'(10);
			3'd2:    p = POW_W'(100);
			3'd3:    p = POW_W'(1000);
			3'd4:    p = POW_W'(10000);
			3'd5:    p = POW_W'(100000);
			default: p = '0;
		endcase
		return p;
	endfunction

endpackage

### rtl/core/dbse_store.sv
`timescale 1ns / 1ps
// Entry store: both tables in one memory, with per-entry written flags.
module dbse_store (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dbse_pkg::mem_req_t             req,
	output logic [dbse_pkg::ENT_W-1:0]     rd_data
);
	import dbse_pkg::*;

	logic [ENT_W-1:0]  mem [SLOTS];
	logic [SLOTS-1:0]  written_q;
	logic [ENT_W-1:0]  rd_q;
	logic              rd_written_q;

	// Write one entry, read one entry with a registered result
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		rd_q <= mem[req.rd_addr];
	end

	// Track which entries hold data; an unwritten entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				written_q[req.wr_addr] <= 1'b1;
			end
			rd_written_q <= written_q[req.rd_addr];
		end
	end

	assign rd_data = rd_written_q ? rd_q : '0;

endmodule

### rtl/core/dbse_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: decode, exponent search, table rescaling sweeps and read scaling.
module dbse_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  dbse_pkg::cmd_t                 in_cmd,
	input  logic [dbse_pkg::IDX_W-1:0]     in_idx,
	input  logic [dbse_pkg::VAL_W-1:0]     in_value,
	input  logic                           slot_free,
	output logic                           res_valid,
	output dbse_pkg::result_t              res,
	output dbse_pkg::mem_req_t             mem_req,
	input  logic [dbse_pkg::ENT_W-1:0]     mem_rdata
);
	import dbse_pkg::*;

	localparam logic [VAL_W-1:0] DIV10_32 = 32'hCCCC_CCCD;
	localparam int               SH10_32  = 35;
	localparam logic [ENT_W-1:0] DIV10_16 = 16'hCCCD;
	localparam int               SH10_16  = 19;

	typedef enum logic [8:0] {
		ST_IDLE    = 9'b000000001,
		ST_RDMUL   = 9'b000000010,
		ST_DIV     = 9'b000000100,
		ST_RAISE   = 9'b000001000,
		ST_STORE   = 9'b000010000,
		ST_SCAN    = 9'b000100000,
		ST_LOWCALC = 9'b001000000,
		ST_LOWER   = 9'b010000000,
		ST_FIN     = 9'b100000000
	} state_t;

	state_t             state_q;
	logic [EXP_W-1:0]   exp_q;
	logic [EXP_W-1:0]   cnt_q;
	logic [EXP_W-1:0]   raise_q;
	logic [EXP_W-1:0]   k_q;
	logic [PTR_W-1:0]   ptr_q;
	logic               sv_s1;
	logic [ADDR_W-1:0]  addr_s1;
	logic [VAL_W-1:0]   q_q;
	logic [ENT_W-1:0]   max_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [VAL_W-1:0]   energy_q;
	logic               rej_q;

	logic               accept;
	logic               in_rej;
	logic               in_wr;
	logic               in_sel;
	logic [ADDR_W-1:0]  in_addr;
	logic               sweeping;
	logic               sweep_done;
	logic               q_big;
	logic               can_lower;
	logic [2*VAL_W-1:0] m32;
	logic [VAL_W-1:0]   div32;
	logic [2*ENT_W-1:0] m16;
	logic [ENT_W-1:0]   div16;
	logic [POW_W-1:0]   pw;
	logic [ENT_W+POW_W-1:0] mp;

	// Decode the incoming transaction
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign in_rej   = ({1'b0, in_idx} >= (IDX_W + 1)'(ENTRIES));
	assign in_wr    = (in_cmd == CMD_WR_IMPORT) || (in_cmd == CMD_WR_EXPORT);
	assign in_sel   = (in_cmd == CMD_WR_EXPORT) || (in_cmd == CMD_RD_EXPORT);
	assign in_addr  = ADDR_W'(in_idx) + (in_sel ? ADDR_W'(ENTRIES) : '0);

	// Sweep bookkeeping
	assign sweeping   = (state_q == ST_RAISE) || (state_q == ST_SCAN) ||
	                    (state_q == ST_LOWER);
	assign sweep_done = (ptr_q == PTR_END) && !sv_s1;
	assign q_big      = (q_q > VAL_W'(ENTRY_MAX));
	assign can_lower  = (max_q < ENT_W'(LOWER_LIMIT)) && (exp_q != '0);

	// Arithmetic: divide by ten via reciprocal, scale by a power of ten
	assign m32   = q_q * DIV10_32;
	assign div32 = VAL_W'(m32[2*VAL_W-1:SH10_32]);
	assign m16   = mem_rdata * DIV10_16;
	assign div16 = ENT_W'(m16[2*ENT_W-1:SH10_16]);
	assign pw    = pow10((state_q == ST_RDMUL) ? exp_q : k_q);
	assign mp    = mem_rdata * pw;

	// Memory access
	always_comb begin
		mem_req.rd_addr = (state_q == ST_IDLE) ? in_addr : ptr_q[ADDR_W-1:0];
		mem_req.wr_en   = 1'b0;
		mem_req.wr_addr = addr_s1;
		mem_req.wr_data = div16;
		unique case (state_q)
			ST_STORE: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = addr_q;
				mem_req.wr_data = q_q[ENT_W-1:0];
			end
			ST_RAISE: begin
				mem_req.wr_en   = sv_s1;
				mem_req.wr_data = div16;
			end
			ST_LOWER: begin
				mem_req.wr_en   = sv_s1;
				mem_req.wr_data = mp[ENT_W-1:0];
			end
			default: begin
				mem_req.wr_en = 1'b0;
			end
		endcase
	end

	// Hand the finished transaction to the output register
	assign res_valid    = (state_q == ST_FIN) && slot_free;
	assign res.energy   = energy_q;
	assign res.exponent = exp_q;
	assign res.rejected = rej_q;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			exp_q   <= EXP_RESET;
			cnt_q   <= '0;
			raise_q <= '0;
			k_q     <= '0;
			ptr_q   <= '0;
			sv_s1   <= 1'b0;
		end else begin
			// advance the sweep pointer, one read per cycle
			if (sweeping && (ptr_q != PTR_END)) begin
				ptr_q <= ptr_q + 1'b1;
				sv_s1 <= 1'b1;
			end else begin
				sv_s1 <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q   <= exp_q;
						raise_q <= '0;
						k_q     <= '0;
						priority if (in_rej) state_q <= ST_FIN;
						else if (in_wr)      state_q <= ST_DIV;
						else                 state_q <= ST_RDMUL;
					end
				end
				ST_RDMUL: begin
					state_q <= ST_FIN;
				end
				ST_DIV: begin
					priority if (cnt_q != '0) begin
						cnt_q <= cnt_q - 1'b1;
					end else if (q_big) begin
						exp_q   <= exp_q + 1'b1;
						raise_q <= raise_q + 1'b1;
					end else begin
						ptr_q   <= '0;
						state_q <= (raise_q != '0) ? ST_RAISE : ST_STORE;
					end
				end
				ST_RAISE: begin
					if (sweep_done) begin
						raise_q <= raise_q - 1'b1;
						ptr_q   <= '0;
						if (raise_q == EXP_W'(1)) state_q <= ST_STORE;
					end
				end
				ST_STORE: begin
					ptr_q   <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (sweep_done) state_q <= ST_LOWCALC;
				end
				ST_LOWCALC: begin
					priority if (can_lower) begin
						exp_q <= exp_q - 1'b1;
						k_q   <= k_q + 1'b1;
					end else if (k_q != '0) begin
						ptr_q   <= '0;
						state_q <= ST_LOWER;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_LOWER: begin
					if (sweep_done) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (slot_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		addr_s1 <= ptr_q[ADDR_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					q_q      <= in_value;
					addr_q   <= in_addr;
					rej_q    <= in_rej;
					energy_q <= '0;
				end
			end
			ST_RDMUL: begin
				energy_q <= (|mp[ENT_W+POW_W-1:VAL_W]) ? '1 : mp[VAL_W-1:0];
			end
			ST_DIV: begin
				if ((cnt_q != '0) || q_big) q_q <= div32;
			end
			ST_STORE: begin
				max_q <= '0;
			end
			ST_SCAN: begin
				if (sv_s1 && (mem_rdata > max_q)) max_q <= mem_rdata;
			end
			ST_LOWCALC: begin
				if (can_lower) max_q <= max_q * ENT_W'(10);
			end
			default: begin
				rej_q <= rej_q;
			end
		endcase
	end

endmodule

### rtl/core/decimal_block_scaled_energy_table.sv
`timescale 1ns / 1ps
// Top level: stream ports, output register, sequencer and entry store.
// One transaction at a time, the next taken the cycle after the result is registered.
// Reset: asynchronous, exponent to one, entries read as zero until written.
module decimal_block_scaled_energy_table (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [5:0] slot_index, [37:6] energy_value, [39:38] zero
	input  logic [dbse_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// [1:0] command
	input  logic [dbse_pkg::CMD_W-1:0]         s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [31:0] read_energy, [34:32] scale_exponent_out, [39:35] zero
	output logic [dbse_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	// [0] index_rejected
	output logic                               m_axis_tuser
);
	import dbse_pkg::*;

	mem_req_t           mem_req;
	logic [ENT_W-1:0]   mem_rdata;
	logic               res_valid;
	result_t            res;
	logic               slot_free;
	logic               out_valid_q;
	result_t            out_q;

	dbse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (cmd_t'(s_axis_tuser)),
		.in_idx    (s_axis_tdata[IDX_W-1:0]),
		.in_value  (s_axis_tdata[IDX_W+VAL_W-1:IDX_W]),
		.slot_free (slot_free),
		.res_valid (res_valid),
		.res       (res),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	dbse_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_data (mem_rdata)
	);

	// Output register: free when empty or being drained this cycle
	assign slot_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the result payload until taken
	always_ff @(posedge clk) begin
		if (res_valid) out_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_q.exponent, out_q.energy};
	assign m_axis_tuser  = out_q.rejected;

endmodule

### rtl/core/dbse_checker.sv
`timescale 1ns / 1ps
// Port checker for the energy table top level, with its bind.
`include "assert_macros.svh"
module dbse_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	input  logic                               s_axis_tready,
	input  logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	input  logic [dbse_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	input  logic                               m_axis_tuser
);
	import dbse_pkg::*;

	// Hold a stalled result
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

	// Drop ready after each accepted transaction
	`ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

	// Exponent stays within its reachable range
	`ASSERT_IMPLIES(a_exp_range, clk, arst_n, m_axis_tvalid, m_axis_tdata[VAL_W+EXP_W-1:VAL_W] <= EXP_W'(EXP_MAX))

	// A rejected index never returns energy
	`ASSERT_IMPLIES(a_reject_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata[VAL_W-1:0] == '0)

endmodule

bind decimal_block_scaled_energy_table dbse_checker u_dbse_checker (.*);
